/* rtl/core/bos_pkg.sv */
// Shared types and codes for the bounded ordered set.
package bos_pkg;

  localparam int unsigned ValueW = 32;
  localparam int unsigned OpW    = 2;
  localparam int unsigned CountW = 5;

  typedef enum logic [OpW-1:0] {
    OP_ADD      = 2'd0,
    OP_REMOVE   = 2'd1,
    OP_CONTAINS = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_UPD
  } state_e;

  // Broadcast from the sequencer to every cell of the chain.
  typedef struct packed {
    logic              cmp;
    logic              append;
    logic              remove;
    logic [ValueW-1:0] value;
  } cell_cmd_t;

endpackage

/* rtl/core/bos_cell.sv */
// One storage cell of the set: holds an entry, its valid bit and a match flag.
module bos_cell (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  bos_pkg::cell_cmd_t          cmd_i,
  input  logic                        prev_valid_i,
  input  logic                        shift_i,
  input  logic [bos_pkg::ValueW-1:0]  next_entry_i,
  input  logic                        next_valid_i,
  output logic [bos_pkg::ValueW-1:0]  entry_o,
  output logic                        valid_o,
  output logic                        match_o,
  output logic                        shift_o
);

  logic [bos_pkg::ValueW-1:0] entry_q, entry_d;
  logic                       valid_q, valid_d;
  logic                       match_q, match_d;
  logic                       first_free;

  // The lowest empty slot is the one whose left neighbor is filled.
  assign first_free = !valid_q && prev_valid_i;
  // Shift when the match sits here or anywhere to the left.
  assign shift_o    = match_q || shift_i;

  always_comb begin
    entry_d = entry_q;
    valid_d = valid_q;
    match_d = match_q;
    if (cmd_i.cmp) begin
      match_d = valid_q && (entry_q == cmd_i.value);
    end
    if (cmd_i.append && first_free) begin
      entry_d = cmd_i.value;
      valid_d = 1'b1;
    end
    if (cmd_i.remove && shift_o) begin
      entry_d = next_entry_i;
      valid_d = next_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      match_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
      match_q <= match_d;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;
  assign valid_o = valid_q;
  assign match_o = match_q;

endmodule

/* rtl/core/bos_chain.sv */
// Row of set cells wired to their neighbors, with the combined match flag.
module bos_chain #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  bos_pkg::cell_cmd_t cmd_i,
  output logic               found_o
);

  logic [bos_pkg::ValueW-1:0] entry [CAPACITY];
  logic [CAPACITY-1:0]        valid;
  logic [CAPACITY-1:0]        match;
  logic [CAPACITY-1:0]        shift;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                       prev_valid;
    logic                       shift_in;
    logic [bos_pkg::ValueW-1:0] next_entry;
    logic                       next_valid;

    if (i == 0) begin : g_head
      assign prev_valid = 1'b1;
      assign shift_in   = 1'b0;
    end else begin : g_body
      assign prev_valid = valid[i-1];
      assign shift_in   = shift[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign next_entry = '0;
      assign next_valid = 1'b0;
    end else begin : g_link
      assign next_entry = entry[i+1];
      assign next_valid = valid[i+1];
    end

    bos_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .cmd_i        (cmd_i),
      .prev_valid_i (prev_valid),
      .shift_i      (shift_in),
      .next_entry_i (next_entry),
      .next_valid_i (next_valid),
      .entry_o      (entry[i]),
      .valid_o      (valid[i]),
      .match_o      (match[i]),
      .shift_o      (shift[i])
    );
  end

  assign found_o = |match;

  // Stored values are distinct, so a lookup hits at most one cell.
  assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot0(match))
    else $error("more than one cell matched");

endmodule

/* rtl/core/bounded_ordered_set_top.sv */
// Top level of the bounded ordered set: request sequencer, entry count, result register.
//
//   channel  | handshake                | payload
//   ---------+--------------------------+-----------------------------------------
//   request  | in_valid_i / in_ready_o  | opcode_i, value_i
//   result   | out_valid_o / out_ready_i| was_present_o, count_after_o,
//            |                          | add_rejected_full_o
//
// A request is accepted, then every cell compares its entry with the value, and then
// the cells append or shift down together in the update state.
// The result is registered and shows in the cycle after the update.
// Reset empties the set at once by clearing the cell valid bits and the count.
// A result left waiting stalls the update state; the next request is not accepted
// until that update has gone through.
module bounded_ordered_set_top #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [bos_pkg::OpW-1:0]            opcode_i,
  input  logic signed [bos_pkg::ValueW-1:0]  value_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic                               was_present_o,
  output logic [bos_pkg::CountW-1:0]         count_after_o,
  output logic                               add_rejected_full_o
);

  localparam int unsigned CntW = $clog2(CAPACITY + 1);

  bos_pkg::state_e            state_q, state_d;
  logic [bos_pkg::OpW-1:0]    op_q;
  logic [bos_pkg::ValueW-1:0] value_q;
  logic [CntW-1:0]            count_q, count_d;
  logic                       out_valid_q, out_valid_d;
  logic                       present_q;
  logic [bos_pkg::CountW-1:0] count_out_q;
  logic                       rejected_q;

  bos_pkg::cell_cmd_t cmd;
  logic               found;
  logic               full;
  logic               upd_go;
  logic               do_append;
  logic               do_remove;
  logic               rejected;

  assign full   = (count_q == CntW'(CAPACITY));
  assign upd_go = (state_q == bos_pkg::ST_UPD) && (!out_valid_q || out_ready_i);

  always_comb begin
    do_append = 1'b0;
    do_remove = 1'b0;
    rejected  = 1'b0;
    unique case (op_q)
      bos_pkg::OP_ADD: begin
        do_append = !found && !full;
        rejected  = !found && full;
      end
      bos_pkg::OP_REMOVE: begin
        do_remove = found;
      end
      default: begin
        // contains, and the unused code that behaves like it
      end
    endcase
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bos_pkg::ST_IDLE: if (in_valid_i) state_d = bos_pkg::ST_CMP;
      bos_pkg::ST_CMP:  state_d = bos_pkg::ST_UPD;
      bos_pkg::ST_UPD:  if (upd_go) state_d = bos_pkg::ST_IDLE;
      default:          state_d = bos_pkg::ST_IDLE;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    in_ready_o = 1'b0;
    cmd        = '{cmp: 1'b0, append: 1'b0, remove: 1'b0, value: value_q};
    unique case (state_q)
      bos_pkg::ST_IDLE: in_ready_o = 1'b1;
      bos_pkg::ST_CMP:  cmd.cmp = 1'b1;
      bos_pkg::ST_UPD: begin
        cmd.append = upd_go && do_append;
        cmd.remove = upd_go && do_remove;
      end
      default: ;
    endcase
  end

  always_comb begin
    count_d = count_q;
    if (upd_go && do_append) begin
      count_d = count_q + CntW'(1);
    end else if (upd_go && do_remove) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i) out_valid_d = 1'b0;
    if (upd_go)      out_valid_d = 1'b1;
  end

  bos_chain #(
    .CAPACITY (CAPACITY)
  ) u_chain (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (cmd),
    .found_o (found)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bos_pkg::ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Capture the request and, on update, the result.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      op_q    <= opcode_i;
      value_q <= value_i;
    end
    if (upd_go) begin
      present_q   <= found;
      count_out_q <= bos_pkg::CountW'(count_d);
      rejected_q  <= rejected;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign was_present_o       = present_q;
  assign count_after_o       = count_out_q;
  assign add_rejected_full_o = rejected_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= CntW'(CAPACITY))
    else $error("entry count above capacity");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (in_valid_i && in_ready_o) |=> (state_q == bos_pkg::ST_CMP))
    else $error("accepted request did not start a compare");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   upd_go |=> (out_valid_q && (state_q == bos_pkg::ST_IDLE)))
    else $error("update did not post a result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (out_valid_q && rejected_q) |-> !present_q)
    else $error("rejected add reported a present value");

endmodule
